// ===== rtl/sgbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbb_pkg: shared types and constants of the sphere grid bounding box
// Field widths, stream packing offsets, register codes, status codes and the
// structs that run between the sequencer and the axis scan units.
// ----------------------------------------------------------------------------
package sgbb_pkg;

  // field widths
  localparam int COORD_W   = 32;  // signed Q16.16 center
  localparam int REG_W     = 31;  // unsigned Q15.16 step and side registers
  localparam int RADIUS_W  = 31;  // unsigned Q15.16 radius
  localparam int NEED_W    = 10;  // required box width
  localparam int BOX_W     = 12;  // signed box ends
  localparam int CFG_IDX_W = 3;

  // default grid size per axis
  localparam int unsigned GRID_POINTS_DEF = 128;

  // register reset values
  localparam logic [REG_W-1:0] STEP_RESET = REG_W'(65536);    // 1.0
  localparam logic [REG_W-1:0] SIDE_RESET = REG_W'(8388608);  // 128.0

  // input tdata layout, lowest bits first
  localparam int IN_CX  = 0;
  localparam int IN_CY  = IN_CX + COORD_W;
  localparam int IN_CZ  = IN_CY + COORD_W;
  localparam int IN_R   = IN_CZ + COORD_W;
  localparam int IN_NX  = IN_R + RADIUS_W;
  localparam int IN_NY  = IN_NX + NEED_W;
  localparam int IN_NZ  = IN_NY + NEED_W;
  localparam int IN_USED = IN_NZ + NEED_W;
  localparam int IN_TDATA_W = ((IN_USED + 7) / 8) * 8;

  // output tdata layout, lowest bits first
  localparam int OUT_LX = 0;
  localparam int OUT_HX = OUT_LX + BOX_W;
  localparam int OUT_LY = OUT_HX + BOX_W;
  localparam int OUT_HY = OUT_LY + BOX_W;
  localparam int OUT_LZ = OUT_HY + BOX_W;
  localparam int OUT_HZ = OUT_LZ + BOX_W;
  localparam int OUT_FX = OUT_HZ + BOX_W;
  localparam int OUT_FY = OUT_FX + 1;
  localparam int OUT_FZ = OUT_FY + 1;
  localparam int OUT_ST = OUT_FZ + 1;
  localparam int OUT_EA = OUT_ST + 2;
  localparam int OUT_USED = OUT_EA + 2;
  localparam int OUT_TDATA_W = ((OUT_USED + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_X = 3'd0,
    REG_STEP_Y = 3'd1,
    REG_STEP_Z = 3'd2,
    REG_SIDE_X = 3'd3,
    REG_SIDE_Y = 3'd4,
    REG_SIDE_Z = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,  // box fits
    ST_WIDE  = 2'd1,  // box larger than required
    ST_SHORT = 2'd2   // shortfall over four, or nothing inside the sphere
  } status_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic load;  // start a new scan
  } axis_ctrl_t;

  typedef struct packed {
    logic                    busy;
    logic signed [BOX_W-1:0] lo;
    logic signed [BOX_W-1:0] hi;
    logic                    fold;
    status_t                 cls;
  } axis_res_t;

endpackage

// ===== rtl/sgbb_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbb_axis: one-axis grid scan unit
// Walks grid indices -N .. 2N-2 one per cycle with a running distance
// register, tracks the first and last index inside the sphere, then pads.
// ----------------------------------------------------------------------------
module sgbb_axis #(
  parameter int unsigned NPTS = sgbb_pkg::GRID_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sgbb_pkg::axis_ctrl_t                   ctrl,
  input  logic signed [sgbb_pkg::COORD_W-1:0]    center,
  input  logic        [sgbb_pkg::REG_W-1:0]      step,
  input  logic        [sgbb_pkg::REG_W-1:0]      side,
  input  logic        [sgbb_pkg::RADIUS_W-1:0]   radius,
  input  logic        [sgbb_pkg::NEED_W-1:0]     need,
  output sgbb_pkg::axis_res_t                    res
);
  import sgbb_pkg::*;

  localparam int IW = $clog2(NPTS) + 3;          // signed grid index
  localparam int DW = 33 + $clog2(2 * NPTS);     // signed distance center - point
  localparam int FW = ((IW > NEED_W) ? IW : NEED_W) + 2;
  localparam int FIRST_I = -int'(NPTS);
  localparam int LAST_I  = 2 * int'(NPTS) - 2;
  localparam logic signed [IW-1:0] IDX_FIRST = IW'(FIRST_I);
  localparam logic signed [IW-1:0] IDX_LAST  = IW'(LAST_I);
  localparam logic [DW-1:0]        SPAN_MUL  = DW'(NPTS);
  localparam logic signed [FW-1:0] HI_FOLD   = FW'(int'(NPTS) - 1);

  logic signed [DW-1:0] dist_r;
  logic signed [IW-1:0] idx_r;
  logic signed [IW-1:0] mn_r;
  logic signed [IW-1:0] mx_r;
  logic                 found_r;
  logic                 busy_r;

  logic signed [DW-1:0] dist_start;
  logic signed [DW-1:0] step_ext;
  logic signed [DW-1:0] rad_ext;
  logic                 in_ball;

  logic signed [FW-1:0] mn_e;
  logic signed [FW-1:0] mx_e;
  logic signed [FW-1:0] width;
  logic signed [FW-1:0] diff;
  logic signed [FW-1:0] lo_f;
  logic signed [FW-1:0] hi_f;
  logic                 fold;
  status_t              cls;

  // distance at index -N is center + N*step
  assign step_ext   = $signed(DW'(step));
  assign rad_ext    = $signed(DW'(radius));
  assign dist_start = DW'(center) + $signed(DW'(step) * SPAN_MUL);
  assign in_ball    = (dist_r < rad_ext) && (dist_r > -rad_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (ctrl.load) begin
      busy_r  <= 1'b1;
      found_r <= 1'b0;
    end else if (busy_r) begin
      if (idx_r == IDX_LAST) begin
        busy_r <= 1'b0;
      end
      if (in_ball) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dist_r <= dist_start;
      idx_r  <= IDX_FIRST;
    end else if (busy_r) begin
      dist_r <= dist_r - step_ext;
      idx_r  <= idx_r + IW'(1);
      if (in_ball && !found_r) begin
        mn_r <= idx_r;
      end
      if (in_ball) begin
        mx_r <= idx_r;
      end
    end
  end

  // even count, one point margin each side, then pad up to the need
  always_comb begin
    mn_e  = FW'(mn_r) - FW'(1);
    mx_e  = FW'(mx_r) + FW'(1) + ((mn_r[0] == mx_r[0]) ? FW'(1) : FW'(0));
    width = mx_e - mn_e + FW'(1);
    diff  = $signed(FW'(need)) - width;
    lo_f  = mn_e;
    hi_f  = mx_e;
    cls   = ST_OK;
    if (!found_r) begin
      lo_f = '0;
      hi_f = '0;
      cls  = ST_SHORT;
    end else if (diff < 0) begin
      cls = ST_WIDE;
    end else if (diff == FW'(1)) begin
      lo_f = mn_e - FW'(1);
    end else if (diff == FW'(2)) begin
      lo_f = mn_e - FW'(1);
      hi_f = mx_e + FW'(1);
    end else if (diff == FW'(3)) begin
      lo_f = mn_e - FW'(2);
      hi_f = mx_e + FW'(1);
    end else if (diff == FW'(4)) begin
      lo_f = mn_e - FW'(2);
      hi_f = mx_e + FW'(2);
    end else if (diff > FW'(4)) begin
      cls = ST_SHORT;
    end
    // whole axis when the sphere spans a cell; status still from the scan
    fold = ({1'b0, side} <= {radius, 1'b0});
    if (fold) begin
      lo_f = '0;
      hi_f = HI_FOLD;
    end
  end

  assign res.busy = busy_r;
  assign res.lo   = BOX_W'(lo_f);
  assign res.hi   = BOX_W'(hi_f);
  assign res.fold = fold;
  assign res.cls  = cls;

endmodule

// ===== rtl/sphere_grid_bounding_box.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_grid_bounding_box: grid box around a sphere, per axis
// Scans each axis for the grid indices inside a sphere and returns a padded
// box per axis with fold flags and a status code.
// ----------------------------------------------------------------------------
// An item passes from input transfer to result through the load, scan and done
// states: each axis unit tests one grid index per cycle over the 3N-1 indices
// -N .. 2N-2, where N is that axis's GRID_X_POINTS, GRID_Y_POINTS or
// GRID_Z_POINTS, and the three axes run side by side. The input is
// not ready while a scan runs; a finished result sits in the output register
// and the next item is taken while it waits. Registers are written on the cfg
// channel, which is always ready, and must only change while no item is in
// flight. Grid point i of an axis lies at step*i; a point counts when its
// distance to the center is strictly below the radius. An axis whose cell side
// is at most twice the radius reports the full range 0 .. N-1.
// ----------------------------------------------------------------------------
module sphere_grid_bounding_box #(
  parameter int unsigned GRID_X_POINTS = sgbb_pkg::GRID_POINTS_DEF,
  parameter int unsigned GRID_Y_POINTS = sgbb_pkg::GRID_POINTS_DEF,
  parameter int unsigned GRID_Z_POINTS = sgbb_pkg::GRID_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // center_x, center_y, center_z, sphere_radius, need_x, need_y, need_z, pad
  input  logic [sgbb_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // low_x, high_x, low_y, high_y, low_z, high_z, fold_x, fold_y, fold_z,
  // status, error_axis, pad
  output logic [sgbb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sgbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgbb_pkg::REG_W-1:0]           cfg_data
);
  import sgbb_pkg::*;

  // configuration registers, order x, y, z
  logic [REG_W-1:0] step_r [3];
  logic [REG_W-1:0] side_r [3];

  // item held for the duration of the scan
  logic signed [COORD_W-1:0] center_r [3];
  logic [NEED_W-1:0]         need_r [3];
  logic [RADIUS_W-1:0]       radius_r;

  fsm_t state_r;
  fsm_t state_nxt;

  axis_ctrl_t ctrl;
  axis_res_t  res [3];
  logic       out_load;
  logic       in_xfer;
  logic       scan_busy;

  logic       out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_pack;
  status_t    status;
  axis_t      err_axis;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid && in_tready;
  assign scan_busy = res[0].busy || res[1].busy || res[2].busy;

  // register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        step_r[a] <= STEP_RESET;
        side_r[a] <= SIDE_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_X: step_r[0] <= cfg_data;
        REG_STEP_Y: step_r[1] <= cfg_data;
        REG_STEP_Z: step_r[2] <= cfg_data;
        REG_SIDE_X: side_r[0] <= cfg_data;
        REG_SIDE_Y: side_r[1] <= cfg_data;
        REG_SIDE_Z: side_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the item on its transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      center_r[0] <= in_tdata[IN_CX +: COORD_W];
      center_r[1] <= in_tdata[IN_CY +: COORD_W];
      center_r[2] <= in_tdata[IN_CZ +: COORD_W];
      radius_r    <= in_tdata[IN_R  +: RADIUS_W];
      need_r[0]   <= in_tdata[IN_NX +: NEED_W];
      need_r[1]   <= in_tdata[IN_NY +: NEED_W];
      need_r[2]   <= in_tdata[IN_NZ +: NEED_W];
    end
  end

  // sequencer: take item, start the axis units, wait, hand off the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (!scan_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ctrl.load = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_LOAD: ctrl.load = 1'b1;
      S_SCAN: ;
      S_DONE: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  sgbb_axis #(.NPTS(GRID_X_POINTS)) u_axis_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .center (center_r[0]),
    .step   (step_r[0]),
    .side   (side_r[0]),
    .radius (radius_r),
    .need   (need_r[0]),
    .res    (res[0])
  );

  sgbb_axis #(.NPTS(GRID_Y_POINTS)) u_axis_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .center (center_r[1]),
    .step   (step_r[1]),
    .side   (side_r[1]),
    .radius (radius_r),
    .need   (need_r[1]),
    .res    (res[1])
  );

  sgbb_axis #(.NPTS(GRID_Z_POINTS)) u_axis_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .center (center_r[2]),
    .step   (step_r[2]),
    .side   (side_r[2]),
    .radius (radius_r),
    .need   (need_r[2]),
    .res    (res[2])
  );

  // an oversized box on any axis wins over a short or empty one;
  // within a class the first axis is reported
  always_comb begin
    status   = ST_OK;
    err_axis = AX_X;
    for (int a = 2; a >= 0; a--) begin
      if (res[a].cls == ST_SHORT) begin
        status   = ST_SHORT;
        err_axis = axis_t'(2'(a));
      end
    end
    for (int a = 2; a >= 0; a--) begin
      if (res[a].cls == ST_WIDE) begin
        status   = ST_WIDE;
        err_axis = axis_t'(2'(a));
      end
    end
  end

  always_comb begin
    out_pack = '0;
    out_pack[OUT_LX +: BOX_W] = res[0].lo;
    out_pack[OUT_HX +: BOX_W] = res[0].hi;
    out_pack[OUT_LY +: BOX_W] = res[1].lo;
    out_pack[OUT_HY +: BOX_W] = res[1].hi;
    out_pack[OUT_LZ +: BOX_W] = res[2].lo;
    out_pack[OUT_HZ +: BOX_W] = res[2].hi;
    out_pack[OUT_FX]          = res[0].fold;
    out_pack[OUT_FY]          = res[1].fold;
    out_pack[OUT_FZ]          = res[2].fold;
    out_pack[OUT_ST +: 2]     = status;
    out_pack[OUT_EA +: 2]     = err_axis;
  end

  // output register: advance on load, drop valid once the transfer is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_pack;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/sgbb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbb_checker: port-level checks of the sphere grid bounding box
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module sgbb_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [sgbb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic                                 out_tvalid,
  input logic                                 out_tready
);
  import sgbb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a scan follows every input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // ok status always names axis x
  a_ok_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[OUT_ST +: 2] == ST_OK) |-> out_tdata[OUT_EA +: 2] == AX_X)
    else $error("error axis set on ok status");

  // status and axis codes stay in range
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_ST +: 2] != 2'd3) && (out_tdata[OUT_EA +: 2] != 2'd3))
    else $error("status or axis code out of range");

  // a folded x axis starts at zero
  a_fold_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_FX] |-> out_tdata[OUT_LX +: BOX_W] == '0)
    else $error("folded x axis does not start at zero");

endmodule

bind sphere_grid_bounding_box sgbb_checker u_sgbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
